>>> hw/rtl/rtp_pkg.sv
// Shared types and constants of the radix integer text parser.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none

package rtp_pkg;

  localparam int CH_W       = 8;
  localparam int VALUE_W    = 64;
  localparam int STATUS_W   = 2;
  localparam int CONS_W     = 12;
  localparam int BASE_W     = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int PROD_W     = VALUE_W + BASE_W;

  localparam int CONS_MAX   = 4095;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED = 4'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_BASE = 2'd2;

  localparam logic [BASE_W-1:0] RADIX_RESET = 6'd10;

  typedef enum logic [2:0] {
    PH_WS   = 3'd0,
    PH_SIGN = 3'd1,
    PH_ZERO = 3'd2,
    PH_PFX  = 3'd3,
    PH_DIG  = 3'd4,
    PH_OVF  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_FIN  = 2'd2
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic finish;
  } sts_t;

  typedef struct packed {
    logic              drain;
    logic              err;
    logic              last;
    logic              take;
    logic              stop;
    logic              add;
    logic              clr;
    logic              neg_wr;
    logic              neg;
    phase_t            phase;
    logic [BASE_W-1:0] base;
    logic [BASE_W-1:0] dig;
  } dec_t;

endpackage

`default_nettype wire

>>> hw/rtl/rtp_if.sv
// Channel interfaces of the parser: character stream, result stream, config writes.
// Depends on rtp_pkg for field widths.
`default_nettype none

interface rtp_stream_if;
  logic                      valid;
  logic                      ready;
  logic [rtp_pkg::CH_W-1:0]  ch;
  logic                      last;
  modport source(output valid, ch, last, input ready);
  modport sink(input valid, ch, last, output ready);
endinterface

interface rtp_result_if;
  logic                          valid;
  logic                          ready;
  logic [rtp_pkg::VALUE_W-1:0]   value;
  logic [rtp_pkg::STATUS_W-1:0]  status;
  logic [rtp_pkg::CONS_W-1:0]    consumed;
  modport source(output valid, value, status, consumed, input ready);
  modport sink(input valid, value, status, consumed, output ready);
endinterface

interface rtp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rtp_pkg::CFG_IDX_W-1:0]   index;
  logic [rtp_pkg::CFG_DATA_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rtp_ctrl.sv
// Sequencer of the parser: input handshake, decode/commit/emit steps, output valid.
// Depends on rtp_pkg.
`default_nettype none

module rtp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire rtp_pkg::sts_t sts,
  output rtp_pkg::cmd_t      cmd
);

  rtp_pkg::ctl_state_t state, state_next;
  logic out_valid_next;
  logic slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rtp_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    slot_free  = !out_valid || out_ready;
    unique case (state)
      rtp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = rtp_pkg::S_EXEC;
        end
      end
      rtp_pkg::S_EXEC: begin
        cmd.commit = 1'b1;
        state_next = sts.finish ? rtp_pkg::S_FIN : rtp_pkg::S_IDLE;
      end
      rtp_pkg::S_FIN: begin
        if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = rtp_pkg::S_IDLE;
        end
      end
      default: state_next = rtp_pkg::S_IDLE;
    endcase
    out_valid_next = cmd.emit || (out_valid && !out_ready);
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == rtp_pkg::S_EXEC))
    else $error("accepted item did not enter execute step");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == rtp_pkg::S_FIN && !slot_free) |=> (state == rtp_pkg::S_FIN && out_valid))
    else $error("pending result dropped while output slot busy");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

endmodule

`default_nettype wire

>>> hw/rtl/rtp_datapath.sv
// Parser datapath: config registers, character decode, 64x6 multiply, overflow
// check, parse state and result register. Depends on rtp_pkg.
`default_nettype none

module rtp_datapath #(
  parameter int MAX_LEN = 4095
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [rtp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rtp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [rtp_pkg::CH_W-1:0]         ch,
  input  wire logic                             last,
  input  wire rtp_pkg::cmd_t                    cmd,
  output rtp_pkg::sts_t                         sts,
  output logic [rtp_pkg::VALUE_W-1:0]           value,
  output logic [rtp_pkg::STATUS_W-1:0]          status,
  output logic [rtp_pkg::CONS_W-1:0]            consumed
);

  localparam int CAP_INT = (MAX_LEN < rtp_pkg::CONS_MAX) ? MAX_LEN : rtp_pkg::CONS_MAX;
  localparam logic [rtp_pkg::CONS_W-1:0] POS_CAP = rtp_pkg::CONS_W'(CAP_INT);

  localparam logic [rtp_pkg::VALUE_W-1:0] SMAX = {1'b0, {(rtp_pkg::VALUE_W-1){1'b1}}};
  localparam logic [rtp_pkg::VALUE_W-1:0] SMIN = {1'b1, {(rtp_pkg::VALUE_W-1){1'b0}}};
  localparam logic [rtp_pkg::VALUE_W-1:0] UMAX = {rtp_pkg::VALUE_W{1'b1}};

  logic [rtp_pkg::BASE_W-1:0]  radix;
  logic                        signed_mode;
  rtp_pkg::phase_t             phase;
  logic                        is_negative;
  logic [rtp_pkg::VALUE_W-1:0] accumulator;
  logic [rtp_pkg::BASE_W-1:0]  active_base;
  logic [rtp_pkg::CONS_W-1:0]  position;
  logic                        draining;

  rtp_pkg::dec_t               dec;
  logic [rtp_pkg::PROD_W-1:0]  product;

  rtp_pkg::dec_t               dn;
  logic                        is_space, is_sign, dv, go_start, go_dig;
  logic [rtp_pkg::BASE_W-1:0]  dig, rad_eff, dig_base;
  logic [rtp_pkg::VALUE_W-1:0] acc_op, limit;
  logic [rtp_pkg::PROD_W-1:0]  prod_wide, sum;
  logic                        ovf, restart;

  // character classes and digit value
  always_comb begin
    is_space = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
    is_sign  = (ch == 8'h2B) || (ch == 8'h2D);
    dv       = 1'b1;
    dig      = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      dig = rtp_pkg::BASE_W'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      dig = rtp_pkg::BASE_W'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      dig = rtp_pkg::BASE_W'(ch - 8'h37);
    end else begin
      dv = 1'b0;
    end
  end

  // decode of one character against the parse state
  always_comb begin
    dn        = '0;
    dn.phase  = phase;
    dn.base   = active_base;
    dn.drain  = draining;
    dn.last   = last;
    dn.dig    = dig;
    dn.err    = (phase == rtp_pkg::PH_WS) && (radix == 6'd1 || radix > 6'd36);
    go_start  = 1'b0;
    go_dig    = 1'b0;
    rad_eff   = (radix == '0) ? 6'd10 : radix;
    dig_base  = (phase == rtp_pkg::PH_ZERO) ? 6'd8 : active_base;
    unique case (phase)
      rtp_pkg::PH_WS: begin
        if (is_space) begin
          dn.take = 1'b1;
        end else if (signed_mode && is_sign) begin
          dn.neg_wr = 1'b1;
          dn.neg    = (ch == 8'h2D);
          dn.phase  = rtp_pkg::PH_SIGN;
          dn.take   = 1'b1;
        end else begin
          dn.phase = rtp_pkg::PH_SIGN;
          go_start = 1'b1;
        end
      end
      rtp_pkg::PH_SIGN: go_start = 1'b1;
      rtp_pkg::PH_ZERO: begin
        if (ch == 8'h78 || ch == 8'h58) begin
          dn.phase = rtp_pkg::PH_PFX;
          dn.take  = 1'b1;
        end else begin
          dn.base  = 6'd8;
          dn.phase = rtp_pkg::PH_DIG;
          go_dig   = 1'b1;
        end
      end
      rtp_pkg::PH_PFX: begin
        if (dv && dig < 6'd16) begin
          dn.base = 6'd16;
          dn.clr  = 1'b1;
          dn.add  = 1'b1;
          dn.take = 1'b1;
        end else begin
          dn.stop = 1'b1;
        end
      end
      default: go_dig = 1'b1;
    endcase
    if (go_start) begin
      if (radix == '0 && ch == 8'h30) begin
        dn.clr   = 1'b1;
        dn.phase = rtp_pkg::PH_ZERO;
        dn.take  = 1'b1;
      end else begin
        dn.base = rad_eff;
        if (dv && dig < rad_eff) begin
          dn.clr  = 1'b1;
          dn.add  = 1'b1;
          dn.take = 1'b1;
        end else begin
          dn.stop = 1'b1;
        end
      end
    end
    if (go_dig) begin
      if (dig_base >= 6'd2 && dv && dig < dig_base) begin
        dn.take = 1'b1;
        dn.add  = (phase != rtp_pkg::PH_OVF);
      end else begin
        dn.stop = 1'b1;
      end
    end
    acc_op    = dn.clr ? '0 : accumulator;
    prod_wide = {{rtp_pkg::BASE_W{1'b0}}, acc_op} * {{rtp_pkg::VALUE_W{1'b0}}, dn.base};
  end

  always_comb begin
    if (!signed_mode) limit = UMAX;
    else              limit = is_negative ? SMIN : SMAX;
    sum        = product + {{rtp_pkg::VALUE_W{1'b0}}, dec.dig};
    ovf        = sum > {{rtp_pkg::BASE_W{1'b0}}, limit};
    sts.finish = !dec.drain && (dec.err || dec.stop || dec.last);
    restart    = (cmd.commit && dec.drain && dec.last) || (cmd.emit && dec.last);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dec     <= dn;
      product <= prod_wide;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= rtp_pkg::RADIX_RESET;
      signed_mode <= 1'b1;
      phase       <= rtp_pkg::PH_WS;
      is_negative <= 1'b0;
      accumulator <= '0;
      active_base <= '0;
      position    <= '0;
      draining    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rtp_pkg::REG_RADIX)  radix       <= cfg_data[rtp_pkg::BASE_W-1:0];
        if (cfg_index == rtp_pkg::REG_SIGNED) signed_mode <= cfg_data[0];
      end
      if (cmd.commit && !dec.drain && !dec.err) begin
        phase       <= dec.phase;
        active_base <= dec.base;
        if (dec.neg_wr) is_negative <= dec.neg;
        if (dec.clr)    accumulator <= '0;
        if (dec.add) begin
          if (ovf) begin
            phase <= rtp_pkg::PH_OVF;
          end else begin
            phase       <= rtp_pkg::PH_DIG;
            accumulator <= sum[rtp_pkg::VALUE_W-1:0];
          end
        end
        if (dec.take && position < POS_CAP) position <= position + 1'b1;
      end
      if (cmd.emit && !dec.last) draining <= 1'b1;
      if (restart) begin
        phase       <= rtp_pkg::PH_WS;
        is_negative <= 1'b0;
        accumulator <= '0;
        active_base <= '0;
        position    <= '0;
        draining    <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      value    <= '0;
      status   <= rtp_pkg::ST_OK;
      consumed <= '0;
      if (dec.err) begin
        status <= rtp_pkg::ST_BAD_BASE;
      end else begin
        unique case (phase)
          rtp_pkg::PH_ZERO: consumed <= position;
          rtp_pkg::PH_PFX:  consumed <= position - 1'b1;
          rtp_pkg::PH_DIG: begin
            value    <= is_negative ? (~accumulator + 1'b1) : accumulator;
            consumed <= position;
          end
          rtp_pkg::PH_OVF: begin
            value    <= limit;
            status   <= rtp_pkg::ST_OVERFLOW;
            consumed <= position;
          end
          default: consumed <= '0;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/radix_integer_text_parser.sv
// Top level of the radix integer text parser: sequencer plus datapath.
// Depends on rtp_pkg, rtp_if, rtp_ctrl and rtp_datapath.
//
// Streams a string one character per item and returns one result per string
// (value, status, consumed) in strtol/strtoull style. Each character passes
// a decode step that registers the 64x6-bit product of the
// accumulator and the base, then a commit step that adds the digit and checks
// the overflow limit. The character that ends the scan also passes a finish
// step that formats the result into the output register once the output slot
// is free. Characters that produce no result are taken while an earlier
// result is still waiting. Config writes are always accepted and must be made
// while the parser is idle. MAX_LEN caps the consumed count (never above 4095).
`default_nettype none

module radix_integer_text_parser #(
  parameter int MAX_LEN = 4095
) (
  input  wire logic    clk,
  input  wire logic    rst,
  rtp_stream_if.sink   text,
  rtp_result_if.source result,
  rtp_cfg_if.sink      cfg
);

  rtp_pkg::cmd_t cmd;
  rtp_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  rtp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (text.valid),
    .in_ready  (text.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rtp_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .ch        (text.ch),
    .last      (text.last),
    .cmd       (cmd),
    .sts       (sts),
    .value     (result.value),
    .status    (result.status),
    .consumed  (result.consumed)
  );

endmodule

`default_nettype wire
